FILE: hw/rtl/s2da_pkg.sv
// ----------------------------------------------------------------------------
// s2da_pkg: shared definitions for the signed integer to decimal text block
// Holds the ASCII codes, the default width and the sequencer state type.
// ----------------------------------------------------------------------------
package s2da_pkg;

    // Default width of the signed input value.
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Width of one output character code.
    localparam int CHAR_WIDTH = 6;

    // ASCII codes, truncated to the character width.
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    // Double dabble correction: a BCD digit at or above five gets three added
    // before the next shift.
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } s2da_state_t;

endpackage

FILE: hw/rtl/s2da_bcd_conv.sv
// ----------------------------------------------------------------------------
// s2da_bcd_conv: iterative binary to BCD converter
// Shift-and-add-three (double dabble), one magnitude bit per clock cycle.
// ----------------------------------------------------------------------------
module s2da_bcd_conv #(
    parameter int VALUE_WIDTH = s2da_pkg::DEFAULT_VALUE_WIDTH,
    parameter int DIGITS      = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [VALUE_WIDTH-1:0]   mag,
    output logic                     done,
    output logic [4*DIGITS-1:0]      bcd
);

    localparam int CntWidth = $clog2(VALUE_WIDTH + 1);
    localparam logic [CntWidth-1:0] CntLoad = CntWidth'(VALUE_WIDTH);
    localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [4*DIGITS-1:0]    bcd_reg;
    logic [4*DIGITS-1:0]    bcd_adj;
    logic [CntWidth-1:0]    cnt_reg;
    logic                   run_reg;
    logic                   done_reg;

    // Each digit is corrected on its own, so this loop is a row of
    // independent adders.
    always_comb
    begin
        logic [3:0] dig;
        for (int i = 0; i < DIGITS; i++)
        begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= s2da_pkg::BCD_ADJ_LIMIT) ?
                                dig + s2da_pkg::BCD_ADJ_ADD : dig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CntLoad;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CntOne;
                if (cnt_reg == CntOne)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag;
            bcd_reg <= '0;
        end
        else if (run_reg)
        begin
            mag_reg <= mag_reg << 1;
            bcd_reg <= {bcd_adj[4*DIGITS-2:0], mag_reg[VALUE_WIDTH-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Renders a two's-complement value as its decimal characters; the digits go out one per cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                     Direction  Handshake
//  -------   -------------------------   ---------  ---------------------------
//  request   start, busy, value          in (busy out) taken when start && !busy
//  result    strobe, character, last_char out       one-cycle strobe per character
//
// Steps: the double dabble converter takes one magnitude bit at a time and
// hands over its digits, a minus sign goes out if needed, leading zeros are
// dropped one digit at a time until the first digit is found, and then the
// digits are sent one at a time. No new request is taken while busy is high.
// Reset clears the sequencer and the strobe; no request is held over. The
// receiver cannot stall: each character is strobed for exactly one cycle.
//
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = s2da_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [VALUE_WIDTH-1:0]         value,
    output logic                                  strobe,
    output logic [s2da_pkg::CHAR_WIDTH-1:0]       character,
    output logic                                  last_char
);

    // Number of decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1),
    // using log10(2) to five places; exact across the supported widths.
    localparam int Digits   = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CntWidth = $clog2(Digits + 1);
    localparam logic [CntWidth-1:0] CntLoad = CntWidth'(Digits);
    localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

    s2da_pkg::s2da_state_t state_reg, state_next;

    logic                            neg_reg, neg_next;
    logic [4*Digits-1:0]             digits_reg, digits_next;
    logic [CntWidth-1:0]             cnt_reg, cnt_next;
    logic                            strobe_reg, strobe_next;
    logic [s2da_pkg::CHAR_WIDTH-1:0] char_reg, char_next;
    logic                            last_reg, last_next;

    logic                            conv_load;
    logic [VALUE_WIDTH-1:0]          conv_mag;
    logic                            conv_done;
    logic [4*Digits-1:0]             conv_bcd;
    logic [3:0]                      top_digit;
    logic [VALUE_WIDTH-1:0]          raw;

    // The magnitude is formed as an unsigned number, so the most negative
    // value negates to itself and reads correctly as 2^(VALUE_WIDTH-1).
    assign raw      = $unsigned(value);
    assign conv_mag = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

    s2da_bcd_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (Digits)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .mag   (conv_mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    assign top_digit = digits_reg[4*Digits-1 -: 4];

    // Sequencer: load the converter, wait for it, send the sign if needed,
    // drop leading zero digits and then send the remaining digits in order.
    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        conv_load   = 1'b0;

        unique case (state_reg)
            s2da_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    conv_load  = 1'b1;
                    neg_next   = raw[VALUE_WIDTH-1];
                    state_next = s2da_pkg::ST_CONVERT;
                end
            end
            s2da_pkg::ST_CONVERT:
            begin
                if (conv_done)
                begin
                    digits_next = conv_bcd;
                    cnt_next    = CntLoad;
                    state_next  = neg_reg ? s2da_pkg::ST_SIGN : s2da_pkg::ST_SKIP;
                end
            end
            s2da_pkg::ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = s2da_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = s2da_pkg::ST_SKIP;
            end
            s2da_pkg::ST_SKIP:
            begin
                // The last digit is always kept, so a zero value gives '0'.
                if (top_digit == 4'd0 && cnt_reg != CntOne)
                begin
                    digits_next = digits_reg << 4;
                    cnt_next    = cnt_reg - CntOne;
                end
                else
                begin
                    state_next = s2da_pkg::ST_EMIT;
                end
            end
            s2da_pkg::ST_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = s2da_pkg::CHAR_ZERO | {2'b00, top_digit};
                last_next   = (cnt_reg == CntOne);
                digits_next = digits_reg << 4;
                cnt_next    = cnt_reg - CntOne;
                if (cnt_reg == CntOne)
                begin
                    state_next = s2da_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = s2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= s2da_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != s2da_pkg::ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    // A character only ever follows a sign or digit step of the sequencer.
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(state_reg) == s2da_pkg::ST_SIGN ||
                    $past(state_reg) == s2da_pkg::ST_EMIT))
        else $error("character strobe without a sign or digit step");

    // The final character of a run leaves the block ready for a new request.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |-> !busy)
        else $error("block still busy after the last character");

    // The converter only finishes while the sequencer is waiting for it.
    a_done_in_convert: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == s2da_pkg::ST_CONVERT))
        else $error("converter finished outside the convert step");

    // The digit count never runs out while digits are skipped or sent.
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == s2da_pkg::ST_SKIP || state_reg == s2da_pkg::ST_EMIT)
        |-> (cnt_reg != '0))
        else $error("digit count exhausted during output");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for signed_int_to_decimal_ascii
// Sends signed values through the start/busy request port and checks every
// character strobed out against decimal text worked out in the bench itself.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH = s2da_pkg::DEFAULT_VALUE_WIDTH;

    // Time to wait after the last expected character before calling the run finished.
    localparam int DRAIN_CYCLES = 60;

    // One character of rendered text, as it should appear on the result ports.
    typedef struct packed {
        logic [s2da_pkg::CHAR_WIDTH-1:0] character;
        logic                            last_char;
    } text_char_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic signed [VALUE_WIDTH-1:0]   value = '0;
    logic                            busy;
    logic                            strobe;
    logic [s2da_pkg::CHAR_WIDTH-1:0] character;
    logic                            last_char;

    // Characters still owed by the block, oldest first.
    text_char_t expected_text[$];
    int         error_count = 0;

    // Percentage of cycles in which the sender holds start low.
    int         sender_idle_pct = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A hard stop in case the block hangs or never raises a strobe.
    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Works out the decimal text of one value and appends it to the queue of
    // expected characters. The magnitude is kept unsigned, so the most
    // negative value yields its true size rather than overflowing.
    function automatic void queue_decimal_text(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digits[$];
        logic                   negative;
        text_char_t             ch;
        negative = v[VALUE_WIDTH-1];
        mag = v;
        if (negative)
        begin
            mag = ~mag + 1'b1;
        end
        if (mag == 0)
        begin
            // Zero is the one case with a single digit and no leading zeros
            // to strip.
            ch.character = s2da_pkg::CHAR_ZERO;
            ch.last_char = 1'b1;
            expected_text.push_back(ch);
            return;
        end
        while (mag != 0)
        begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        if (negative)
        begin
            ch.character = s2da_pkg::CHAR_MINUS;
            ch.last_char = 1'b0;
            expected_text.push_back(ch);
        end
        foreach (digits[i])
        begin
            ch.character = s2da_pkg::CHAR_ZERO + digits[i];
            ch.last_char = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    // Checks each strobed character against the oldest one still owed. The
    // receiver cannot stall, so every strobe is taken at the edge ending it.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected character %0d with last_char %0d", character, last_char);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (character !== want.character)
                begin
                    $error("character: expected %0d, actual %0d", want.character, character);
                    error_count++;
                end
                if (last_char !== want.last_char)
                begin
                    $error("last_char: expected %0d, actual %0d", want.last_char, last_char);
                    error_count++;
                end
            end
        end
    end

    // Issues one request. In each cycle the sender holds start low with the
    // idle percentage; the request is taken at the first edge where start is
    // high and the block is not busy.
    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
        logic offered;
        logic taken;
        taken = 1'b0;
        value <= v;
        while (!taken)
        begin
            offered = (int'($urandom_range(99)) >= sender_idle_pct);
            start <= offered;
            @(posedge clk);
            taken = offered && !busy;
        end
        // The request was taken at this edge.
        queue_decimal_text(v);
    endtask

    task automatic apply_reset();
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    // Zero and the smallest magnitudes of either sign.
    task automatic test_zero_and_unit();
        send_value(0);
        send_value(1);
        send_value(-1);
    endtask

    // The ends of the signed range, where the most negative value must not
    // overflow when its magnitude is taken.
    task automatic test_range_extremes();
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(32'sh8000_0001);
        send_value(32'sh7FFF_FFFE);
    endtask

    // Values either side of a change in digit count, so that leading zero
    // suppression is checked at one, two, three, nine and ten digits.
    task automatic test_digit_counts();
        send_value(9);
        send_value(10);
        send_value(-99);
        send_value(-100);
        send_value(999_999_999);
        send_value(1_000_000_000);
        send_value(-999_999_999);
        send_value(-1_000_000_000);
    endtask

    // Alternating bit patterns, each bit of the value taking both levels.
    task automatic test_bit_patterns();
        send_value(32'sh5555_5555);
        send_value(32'shAAAA_AAAA);
    endtask

    // Random values: a mix of full-width words, magnitudes of random length,
    // values near the range ends and values next to powers of ten.
    task automatic test_random_values(input int count, input int idle_pct);
        logic [VALUE_WIDTH-1:0]        span;
        logic [VALUE_WIDTH-1:0]        mag;
        logic signed [VALUE_WIDTH-1:0] v;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            case ($urandom_range(3))
                0: v = $urandom;
                1:
                begin
                    span = 1;
                    repeat ($urandom_range(1, 9)) span = span * 10;
                    mag = $urandom_range(span - 1, 0);
                    v = $urandom_range(1) ? -mag : mag;
                end
                2:
                begin
                    if ($urandom_range(1))
                    begin
                        v = 32'h8000_0000 + $urandom_range(3);
                    end
                    else
                    begin
                        v = 32'h7FFF_FFFF - $urandom_range(3);
                    end
                end
                default:
                begin
                    span = 1;
                    repeat ($urandom_range(1, 9)) span = span * 10;
                    mag = span + $urandom_range(2) - 1;
                    v = $urandom_range(1) ? -mag : mag;
                end
            endcase
            send_value(v);
        end
    endtask

    initial
    begin
        apply_reset();

        sender_idle_pct = 38;
        test_zero_and_unit();
        test_range_extremes();
        test_digit_counts();
        test_bit_patterns();

        // The sender idles now and then, then most of the time, then never.
        test_random_values(85, 38);
        test_random_values(85, 87);
        test_random_values(85, 0);

        // The last request was taken at this edge; nothing more is offered.
        start <= 1'b0;
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        // Give the block time to show any character it should not send.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
